// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the checker files
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, off while reset is asserted
`define ASSERT_IMP_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// next-cycle implication that also holds across reset
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/eos_pkg.sv =====
// ---------------------------------------------------------------------------
// eos_pkg
// types and constants of the elevator order scheduler
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package eos_pkg;

  localparam int FLOOR_COUNT = 4;
  localparam int FLOOR_IDX_W = (FLOOR_COUNT > 1) ? $clog2(FLOOR_COUNT) : 1;
  // width wide enough to compare a scan index with the 2-bit floor field
  localparam int CMP_W = (FLOOR_IDX_W > 2) ? FLOOR_IDX_W : 2;

  // request kinds
  localparam logic [1:0] KIND_REGISTER  = 2'd0;
  localparam logic [1:0] KIND_CLR_FLOOR = 2'd1;
  localparam logic [1:0] KIND_CLR_ALL   = 2'd2;
  localparam logic [1:0] KIND_QUERY     = 2'd3;

  // button codes, also the bit position in one floor's order word
  localparam logic [1:0] BTN_HALL_UP   = 2'd0;
  localparam logic [1:0] BTN_HALL_DOWN = 2'd1;
  localparam logic [1:0] BTN_CABIN     = 2'd2;

  // direction codes
  localparam logic signed [1:0] DIR_DOWN = -2'sd1;
  localparam logic signed [1:0] DIR_STOP = 2'sd0;
  localparam logic signed [1:0] DIR_UP   = 2'sd1;

  typedef logic [2:0] order_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_UPDATE = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_EMIT   = 4'b1000
  } state_t;

endpackage

// ===== rtl/elevator_order_scheduler_unit.sv =====
// ---------------------------------------------------------------------------
// elevator_order_scheduler_unit
// scan-style elevator order store with stop and next-direction decision
// ---------------------------------------------------------------------------
// Each request applies one update to the per-floor order bits (register a
// hall up, hall down or cabin order, clear one floor, clear all, or nothing)
// and then yields one result: whether the car stops at the request's floor
// and which way it travels next. After acceptance the request passes through
// the update step, which applies the update, the scan, in which a single
// shared compare unit walks the order store one floor per cycle to find
// orders above and below the floor, and the result step, which forms the
// result. in_stall is high from acceptance until the result is loaded into
// the output register, so a new request is taken only once the previous
// result is loaded; the result step waits while a previous result is still
// held by out_stall. The output register lets the next request be accepted
// while a result still waits on out_stall.
`timescale 1ns / 1ps

module elevator_order_scheduler_unit
  import eos_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // request channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_kind,
  input  logic [1:0]        in_button,
  input  logic [1:0]        in_floor,
  input  logic signed [1:0] in_direction,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_stop_here,
  output logic signed [1:0] out_next_direction
);

  // sequencer state
  state_t state_r, state_nxt;

  // captured request fields
  logic [1:0]        kind_r;
  logic [1:0]        button_r;
  logic [1:0]        floor_r;
  logic signed [1:0] dir_r;

  // order store, one word per floor
  order_t order_r [FLOOR_COUNT];

  // scan index and the two running flags of the shared compare unit
  logic [FLOOR_IDX_W-1:0] scan_r, scan_nxt;
  logic above_r, above_nxt;
  logic below_r, below_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic              stop_r;
  logic signed [1:0] next_dir_r;

  logic in_fire;
  logic out_free;
  logic floor_ok;
  logic [FLOOR_IDX_W-1:0] floor_idx;
  logic scan_last;
  logic scan_hit;
  logic scan_is_above;
  logic scan_is_below;
  order_t here;
  logic going_up;
  logic going_down;
  logic stop_calc;
  logic signed [1:0] dir_calc;

  assign in_fire  = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  // output slot can take a new result this cycle
  assign out_free = !out_valid_r || !out_stall;

  // floors beyond the store hold no orders and never get updated
  assign floor_ok  = (int'(floor_r) < FLOOR_COUNT);
  assign floor_idx = FLOOR_IDX_W'(floor_r);

  // shared compare unit: one floor per cycle against the request floor
  assign scan_last     = (scan_r == FLOOR_IDX_W'(FLOOR_COUNT - 1));
  assign scan_hit      = |order_r[scan_r];
  assign scan_is_above = CMP_W'(scan_r) > CMP_W'(floor_r);
  assign scan_is_below = CMP_W'(scan_r) < CMP_W'(floor_r);

  // decision from the finished scan
  assign here       = floor_ok ? order_r[floor_idx] : '0;
  assign going_up   = (dir_r == DIR_UP);
  assign going_down = (dir_r == DIR_DOWN);

  always_comb begin
    if (here[BTN_CABIN]) begin
      stop_calc = 1'b1;
    end else if (going_up) begin
      stop_calc = here[BTN_HALL_UP] || !above_r;
    end else if (going_down) begin
      stop_calc = here[BTN_HALL_DOWN] || !below_r;
    end else begin
      // stopped, or the unused direction pattern
      stop_calc = 1'b1;
    end

    // keep heading while orders lie ahead, else up, else down, else stop
    if (going_up && above_r) begin
      dir_calc = DIR_UP;
    end else if (going_down && below_r) begin
      dir_calc = DIR_DOWN;
    end else if (above_r) begin
      dir_calc = DIR_UP;
    end else if (below_r) begin
      dir_calc = DIR_DOWN;
    end else begin
      dir_calc = DIR_STOP;
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    scan_nxt      = scan_r;
    above_nxt     = above_r;
    below_nxt     = below_r;
    out_valid_nxt = out_valid_r && out_stall;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        // update lands this cycle, scan starts on the new store contents
        scan_nxt  = '0;
        above_nxt = 1'b0;
        below_nxt = 1'b0;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        above_nxt = above_r || (scan_hit && scan_is_above);
        below_nxt = below_r || (scan_hit && scan_is_below);
        if (scan_last) begin
          state_nxt = ST_EMIT;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end
      ST_EMIT: begin
        // hold the result until the output slot frees up
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      scan_r      <= '0;
      above_r     <= 1'b0;
      below_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      scan_r      <= scan_nxt;
      above_r     <= above_nxt;
      below_r     <= below_nxt;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r   <= in_kind;
      button_r <= in_button;
      floor_r  <= in_floor;
      dir_r    <= in_direction;
    end
  end

  // order store update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < FLOOR_COUNT; i++) begin
        order_r[i] <= '0;
      end
    end else if (state_r == ST_UPDATE) begin
      case (kind_r)
        KIND_REGISTER: begin
          // button code 3 means nothing and is dropped
          if (floor_ok && (button_r != 2'd3)) begin
            order_r[floor_idx][button_r] <= 1'b1;
          end
        end
        KIND_CLR_FLOOR: begin
          if (floor_ok) begin
            order_r[floor_idx] <= '0;
          end
        end
        KIND_CLR_ALL: begin
          for (int i = 0; i < FLOOR_COUNT; i++) begin
            order_r[i] <= '0;
          end
        end
        KIND_QUERY: begin
        end
        default: begin
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if ((state_r == ST_EMIT) && out_free) begin
      stop_r     <= stop_calc;
      next_dir_r <= dir_calc;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_stop_here      = stop_r;
  assign out_next_direction = next_dir_r;

endmodule

// ===== rtl/eos_checker.sv =====
// ---------------------------------------------------------------------------
// eos_checker
// port-level checks of the elevator order scheduler, bound to the top level
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module eos_checker
  import eos_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic [1:0]        in_kind,
  input logic [1:0]        in_button,
  input logic [1:0]        in_floor,
  input logic signed [1:0] in_direction,
  input logic              out_valid,
  input logic              out_stall,
  input logic              out_stop_here,
  input logic signed [1:0] out_next_direction
);

  // the block works on one request at a time
  `ASSERT_IMP_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)

  // no stale result survives reset
  `ASSERT_NEXT_ALWAYS(a_no_result_after_reset, clk, !rst_n, !out_valid)

  // passing a floor means orders lie ahead, so the car keeps moving
  `ASSERT_IMP(a_pass_means_move, clk, rst_n, out_valid && !out_stop_here,
              out_next_direction != DIR_STOP)

  // a waiting result holds still
  `ASSERT_IMP_NEXT(a_result_held, clk, rst_n, out_valid && out_stall,
                   out_valid && $stable(out_stop_here) && $stable(out_next_direction))

endmodule

bind elevator_order_scheduler_unit eos_checker u_eos_checker (.*);
